/* sv/jfse_pkg.sv */
// jfse_pkg: shared types, codes and constants for the json field stream extractor
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package jfse_pkg;

	// default window depth
	localparam int PATTERN_MAX_DEF = 8;

	// field widths
	localparam int REQ_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;
	localparam int PAT_W   = 64;
	localparam int LEN_W   = 4;
	localparam int TICK_W  = 16;
	localparam int CIDX_W  = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_START = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHAR      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DONE      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_END       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SEARCH_TO = 3'd3;
	localparam logic [KIND_W-1:0] KIND_VALUE_TO  = 3'd4;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_KEY_PATTERN   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_KEY_LENGTH    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_END_PATTERN   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_END_LENGTH    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_VALUE_MODE    = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd5;

	// register reset values
	localparam logic [LEN_W-1:0]  KEY_LENGTH_RST    = 4'd1;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1500;

	// characters
	localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// configuration seen by the datapath
	typedef struct packed {
		logic [PAT_W-1:0]  key_pattern;
		logic [LEN_W-1:0]  key_length;
		logic [PAT_W-1:0]  end_pattern;
		logic [LEN_W-1:0]  end_length;
		logic              value_mode;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	// window control from the core
	typedef struct packed {
		logic             preset;
		logic             shift;
		logic [BYTE_W-1:0] data;
	} win_ctl_t;

	// window match status to the core
	typedef struct packed {
		logic key_hit;
		logic end_hit;
	} win_match_t;

endpackage

/* sv/jfse_req_if.sv */
// jfse_req_if: request channel (valid/ready with request type and byte)
// depends on jfse_pkg
`timescale 1ns / 1ps

interface jfse_req_if
	import jfse_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

/* sv/jfse_res_if.sv */
// jfse_res_if: result channel (valid/ready with result kind and character)
// depends on jfse_pkg
`timescale 1ns / 1ps

interface jfse_res_if
	import jfse_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] out_kind;
	logic [BYTE_W-1:0] out_char;

	modport source (output valid, output out_kind, output out_char, input ready);
	modport sink (input valid, input out_kind, input out_char, output ready);
endinterface

/* sv/json_field_stream_extractor.sv */
// json_field_stream_extractor: top level, config registers, window compare and core
// depends on jfse_pkg, jfse_req_if, jfse_res_if, jfse_cfg_regs, jfse_window, jfse_core
//
// channel  | dir | handshake   | payload
// ---------+-----+-------------+----------------------------------
// req      | in  | valid/ready | req_type[1:0], in_byte[7:0]
// res      | out | valid/ready | out_kind[2:0], out_char[7:0]
// cfg      | in  | cfg_we      | cfg_index[2:0], cfg_wdata[63:0]
//
// one transaction per cycle unless a stalled result holds stage 1; each passes the input
// register, and any result it produces is captured in the result register
// the window compare, phase update and result select all sit between those two registers
// a stalled result holds the result register and stalls stage 1 behind it; req stays
// ready while stage 1 is empty or draining
// reset is asynchronous and immediate: idle phase, window all '@', no clearing pass
`timescale 1ns / 1ps

module json_field_stream_extractor
	import jfse_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]  cfg_wdata,
	jfse_req_if.sink          req,
	jfse_res_if.source        res
);

	cfg_t       cfg;
	win_ctl_t   ctl;
	win_match_t match;

	// configuration registers
	jfse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sliding window and suffix compare
	jfse_window #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctl    (ctl),
		.match  (match)
	);

	// control and result path
	jfse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.match  (match),
		.ctl    (ctl),
		.req    (req),
		.res    (res)
	);

endmodule

/* sv/jfse_cfg_regs.sv */
// jfse_cfg_regs: configuration register file written through a plain write port
// depends on jfse_pkg
`timescale 1ns / 1ps

module jfse_cfg_regs
	import jfse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]  cfg_wdata,
	output cfg_t              cfg
);

	logic [PAT_W-1:0]  key_pattern_q;
	logic [LEN_W-1:0]  key_length_q;
	logic [PAT_W-1:0]  end_pattern_q;
	logic [LEN_W-1:0]  end_length_q;
	logic              value_mode_q;
	logic [TICK_W-1:0] timeout_ticks_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pattern_q   <= '0;
			key_length_q    <= KEY_LENGTH_RST;
			end_pattern_q   <= '0;
			end_length_q    <= '0;
			value_mode_q    <= 1'b0;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_PATTERN:   key_pattern_q   <= cfg_wdata;
				CFG_KEY_LENGTH:    key_length_q    <= cfg_wdata[LEN_W-1:0];
				CFG_END_PATTERN:   end_pattern_q   <= cfg_wdata;
				CFG_END_LENGTH:    end_length_q    <= cfg_wdata[LEN_W-1:0];
				CFG_VALUE_MODE:    value_mode_q    <= cfg_wdata[0];
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.key_pattern   = key_pattern_q;
	assign cfg.key_length    = key_length_q;
	assign cfg.end_pattern   = end_pattern_q;
	assign cfg.end_length    = end_length_q;
	assign cfg.value_mode    = value_mode_q;
	assign cfg.timeout_ticks = timeout_ticks_q;

endmodule

/* sv/jfse_window.sv */
// jfse_window: sliding byte window with parallel suffix compare for key and end marker
// depends on jfse_pkg; the compare sees the window as it stands after the incoming byte
`timescale 1ns / 1ps

module jfse_window
	import jfse_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  win_ctl_t   ctl,
	output win_match_t match
);

	logic [BYTE_W-1:0] win_q [PATTERN_MAX];
	logic [BYTE_W-1:0] win_next [PATTERN_MAX];
	logic [LEN_W-1:0]  key_len;
	logic [LEN_W-1:0]  end_len;

	// window with the incoming byte shifted in at the newest end
	always_comb begin
		win_next[0] = ctl.data;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	// lengths above the window depth count as the full depth
	assign key_len = (cfg.key_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
		: cfg.key_length;
	assign end_len = (cfg.end_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
		: cfg.end_length;

	// suffix compare, one lane per window byte
	always_comb begin
		match.key_hit = 1'b1;
		match.end_hit = (end_len != '0);
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (LEN_W'(i) < key_len && win_next[i] != cfg.key_pattern[BYTE_W*i +: BYTE_W]) begin
				match.key_hit = 1'b0;
			end
			if (LEN_W'(i) < end_len && win_next[i] != cfg.end_pattern[BYTE_W*i +: BYTE_W]) begin
				match.end_hit = 1'b0;
			end
		end
	end

	// window storage, preset to '@'
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= CH_AT;
			end
		end else if (ctl.preset) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= CH_AT;
			end
		end else if (ctl.shift) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

endmodule

/* sv/jfse_core.sv */
// jfse_core: input register, phase and timeout control, result register
// depends on jfse_pkg, jfse_req_if, jfse_res_if; drives jfse_window through win_ctl_t
`timescale 1ns / 1ps

module jfse_core
	import jfse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  win_match_t match,
	output win_ctl_t   ctl,
	jfse_req_if.sink   req,
	jfse_res_if.source res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEARCH,
		PH_VALUE
	} phase_t;

	logic              req_valid_s1;
	logic [REQ_W-1:0]  req_type_s1;
	logic [BYTE_W-1:0] in_byte_s1;

	phase_t            phase_q;
	phase_t            phase_d;
	logic [TICK_W-1:0] ticks_q;
	logic [TICK_W-1:0] ticks_d;

	logic              res_valid_s2;
	logic [KIND_W-1:0] res_kind_s2;
	logic [BYTE_W-1:0] res_char_s2;

	logic              adv;
	logic              emit;
	logic [KIND_W-1:0] emit_kind;
	logic [BYTE_W-1:0] emit_char;
	logic              is_digit;

	// stage 1 moves on when the result register is free or being drained
	assign adv       = req_valid_s1 && (!res_valid_s2 || res.ready);
	assign req.ready = !req_valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			req_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			in_byte_s1  <= req.in_byte;
		end
	end

	assign is_digit = (in_byte_s1 >= CH_ZERO) && (in_byte_s1 <= CH_NINE);

	// window control
	assign ctl.preset = adv && (req_type_s1 == REQ_START);
	assign ctl.shift  = adv && (req_type_s1 == REQ_BYTE) && (phase_q == PH_SEARCH);
	assign ctl.data   = in_byte_s1;

	// next state and result for the transaction in stage 1
	always_comb begin
		phase_d   = phase_q;
		ticks_d   = ticks_q;
		emit      = 1'b0;
		emit_kind = KIND_CHAR;
		emit_char = '0;
		case (req_type_s1)
			REQ_START: begin
				phase_d = PH_SEARCH;
				ticks_d = cfg.timeout_ticks;
			end
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (ticks_q <= TICK_W'(1)) begin
						emit      = 1'b1;
						emit_kind = (phase_q == PH_SEARCH) ? KIND_SEARCH_TO : KIND_VALUE_TO;
						phase_d   = PH_IDLE;
						ticks_d   = '0;
					end else begin
						ticks_d = ticks_q - TICK_W'(1);
					end
				end
			end
			REQ_BYTE: begin
				if (phase_q == PH_SEARCH) begin
					// key wins over end marker
					if (match.key_hit) begin
						phase_d = PH_VALUE;
						ticks_d = cfg.timeout_ticks;
					end else if (match.end_hit) begin
						emit      = 1'b1;
						emit_kind = KIND_END;
						phase_d   = PH_IDLE;
					end
				end else if (phase_q == PH_VALUE) begin
					emit = 1'b1;
					if (cfg.value_mode ? !is_digit : (in_byte_s1 == CH_QUOTE)) begin
						emit_kind = KIND_DONE;
						phase_d   = PH_IDLE;
					end else begin
						emit_char = in_byte_s1;
					end
				end
			end
			default: ;
		endcase
	end

	// phase, tick counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			ticks_q      <= '0;
			res_valid_s2 <= 1'b0;
			res_kind_s2  <= KIND_CHAR;
			res_char_s2  <= '0;
		end else begin
			if (adv) begin
				phase_q <= phase_d;
				ticks_q <= ticks_d;
			end
			if (adv && emit) begin
				res_valid_s2 <= 1'b1;
				res_kind_s2  <= emit_kind;
				res_char_s2  <= emit_char;
			end else if (res.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	assign res.valid    = res_valid_s2;
	assign res.out_kind = res_kind_s2;
	assign res.out_char = res_char_s2;

	// a terminating result always leaves the block idle
	a_term_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && emit_kind != KIND_CHAR |=> phase_q == PH_IDLE)
		else $error("terminating result did not return to idle");

	// value characters only come out of the value phase
	a_char_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && emit_kind == KIND_CHAR |-> phase_q == PH_VALUE)
		else $error("value character outside value phase");

	// a start loads the timeout and enters search
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_type_s1 == REQ_START
		|=> phase_q == PH_SEARCH && ticks_q == $past(cfg.timeout_ticks))
		else $error("start did not load the search phase");

	// status results carry no character
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_kind_s2 != KIND_CHAR |-> res_char_s2 == '0)
		else $error("status result with nonzero character");

	// an unaccepted result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && !res.ready |-> !adv)
		else $error("result register overrun");

endmodule
